// ----- hw/rtl/sarf_pkg.sv -----
// Shared widths and axis codes for the rotated-frame axis snapper.
`timescale 1ns / 1ps

package sarf_pkg;

    // Default fraction bits of the Q1.F quaternion and matrix entries
    localparam int FRAC_BITS_DEF = 14;

    // Fixed field widths
    localparam int AXIS_W = 16;
    localparam int QUAT_W = 16;
    localparam int OUT_W  = 16;
    localparam int IDX_W  = 2;

    // Stream packing
    localparam int IN_DATA_W  = 7 * AXIS_W;
    localparam int SNAP_W     = 3 * OUT_W;
    localparam int OUT_DATA_W = ((SNAP_W + 7) / 8) * 8;
    localparam int OUT_USER_W = IDX_W + 1;

    // Body axis codes
    localparam logic [IDX_W-1:0] IDX_X    = 2'd0;
    localparam logic [IDX_W-1:0] IDX_Y    = 2'd1;
    localparam logic [IDX_W-1:0] IDX_Z    = 2'd2;
    localparam logic [IDX_W-1:0] IDX_RSVD = 2'd3;

endpackage

// ----- hw/rtl/sarf_quat_mat.sv -----
// Quaternion to rotation matrix columns: products, sums, round and saturate.
`timescale 1ns / 1ps

module sarf_quat_mat import sarf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int COL_W = FRAC_BITS + 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic signed [AXIS_W-1:0] axis_i [3],
    input  logic signed [QUAT_W-1:0] quat_w,
    input  logic signed [QUAT_W-1:0] quat_x,
    input  logic signed [QUAT_W-1:0] quat_y,
    input  logic signed [QUAT_W-1:0] quat_z,
    output logic                     out_vld,
    output logic signed [AXIS_W-1:0] axis_o [3],
    output logic signed [COL_W-1:0]  col_o [9]
);

    localparam int PROD_W = 2 * QUAT_W;
    localparam int SUM_W  = ((2 * FRAC_BITS + 2 > PROD_W + 2) ?
                             2 * FRAC_BITS + 2 : PROD_W + 2) + 1;

    // Product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    localparam logic signed [SUM_W-1:0] ONE2     = SUM_W'(1) << (2 * FRAC_BITS);
    localparam logic signed [SUM_W-1:0] HALF     = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [SUM_W-1:0] ONE_W    = SUM_W'(1) << FRAC_BITS;
    localparam logic signed [SUM_W-1:0] NEG_ONE_W = -ONE_W;
    localparam logic signed [COL_W-1:0] ONE_C    = COL_W'(1) << FRAC_BITS;
    localparam logic signed [COL_W-1:0] NEG_ONE_C = -ONE_C;

    logic                     vld1_reg, vld2_reg, vld3_reg;
    logic signed [AXIS_W-1:0] axis1_reg [3];
    logic signed [AXIS_W-1:0] axis2_reg [3];
    logic signed [AXIS_W-1:0] axis3_reg [3];
    logic signed [PROD_W-1:0] prod_reg  [9];
    logic signed [PROD_W-1:0] prod_next [9];
    logic signed [SUM_W-1:0]  ent_reg   [9];
    logic signed [SUM_W-1:0]  ent_next  [9];
    logic signed [SUM_W-1:0]  pw        [9];
    logic signed [COL_W-1:0]  col_reg   [9];
    logic signed [COL_W-1:0]  col_next  [9];

    // Round half up to Q1.F and clamp to [-1, 1]
    function automatic logic signed [COL_W-1:0] to_q(input logic signed [SUM_W-1:0] e);
        logic signed [SUM_W-1:0] t;
        logic signed [SUM_W-1:0] r;
        t = e + HALF;
        r = t >>> FRAC_BITS;
        if (r > ONE_W) begin
            return ONE_C;
        end else if (r < NEG_ONE_W) begin
            return NEG_ONE_C;
        end
        return COL_W'(r);
    endfunction

    // Form the nine quaternion products
    always_comb begin
        prod_next[P_XX] = PROD_W'(quat_x) * PROD_W'(quat_x);
        prod_next[P_YY] = PROD_W'(quat_y) * PROD_W'(quat_y);
        prod_next[P_ZZ] = PROD_W'(quat_z) * PROD_W'(quat_z);
        prod_next[P_XY] = PROD_W'(quat_x) * PROD_W'(quat_y);
        prod_next[P_XZ] = PROD_W'(quat_x) * PROD_W'(quat_z);
        prod_next[P_YZ] = PROD_W'(quat_y) * PROD_W'(quat_z);
        prod_next[P_WX] = PROD_W'(quat_w) * PROD_W'(quat_x);
        prod_next[P_WY] = PROD_W'(quat_w) * PROD_W'(quat_y);
        prod_next[P_WZ] = PROD_W'(quat_w) * PROD_W'(quat_z);
    end

    // Build the exact matrix entries, column by column
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            pw[i] = SUM_W'(prod_reg[i]);
        end
        ent_next[0] = ONE2 - ((pw[P_YY] + pw[P_ZZ]) <<< 1);
        ent_next[1] = (pw[P_XY] + pw[P_WZ]) <<< 1;
        ent_next[2] = (pw[P_XZ] - pw[P_WY]) <<< 1;
        ent_next[3] = (pw[P_XY] - pw[P_WZ]) <<< 1;
        ent_next[4] = ONE2 - ((pw[P_XX] + pw[P_ZZ]) <<< 1);
        ent_next[5] = (pw[P_YZ] + pw[P_WX]) <<< 1;
        ent_next[6] = (pw[P_XZ] + pw[P_WY]) <<< 1;
        ent_next[7] = (pw[P_YZ] - pw[P_WX]) <<< 1;
        ent_next[8] = ONE2 - ((pw[P_XX] + pw[P_YY]) <<< 1);
    end

    // Round and clamp each entry
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            col_next[i] = to_q(ent_reg[i]);
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= prod_next;
            ent_reg   <= ent_next;
            col_reg   <= col_next;
            axis1_reg <= axis_i;
            axis2_reg <= axis1_reg;
            axis3_reg <= axis2_reg;
        end
    end

    assign out_vld = vld3_reg;
    assign axis_o  = axis3_reg;
    assign col_o   = col_reg;

endmodule

// ----- hw/rtl/sarf_body_dot.sv -----
// Body-frame components: column times vector products, then three-term sums.
`timescale 1ns / 1ps

module sarf_body_dot import sarf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int COL_W  = FRAC_BITS + 2,
    localparam int BODY_W = COL_W + AXIS_W + 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic signed [AXIS_W-1:0] axis_i [3],
    input  logic signed [COL_W-1:0]  col_i [9],
    output logic                     out_vld,
    output logic signed [COL_W-1:0]  col_o [9],
    output logic signed [BODY_W-1:0] body_o [3]
);

    localparam int MUL_W = COL_W + AXIS_W;

    logic                     vld4_reg, vld5_reg;
    logic signed [MUL_W-1:0]  mul_reg  [9];
    logic signed [MUL_W-1:0]  mul_next [9];
    logic signed [BODY_W-1:0] body_reg  [3];
    logic signed [BODY_W-1:0] body_next [3];
    logic signed [COL_W-1:0]  col4_reg [9];
    logic signed [COL_W-1:0]  col5_reg [9];

    // Multiply each column entry by its vector component
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                mul_next[k*3+i] = MUL_W'(col_i[k*3+i]) * MUL_W'(axis_i[i]);
            end
        end
    end

    // Sum the three products of each column
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            body_next[k] = BODY_W'(mul_reg[k*3]) + BODY_W'(mul_reg[k*3+1])
                         + BODY_W'(mul_reg[k*3+2]);
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else if (en) begin
            vld4_reg <= in_vld;
            vld5_reg <= vld4_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            mul_reg  <= mul_next;
            body_reg <= body_next;
            col4_reg <= col_i;
            col5_reg <= col4_reg;
        end
    end

    assign out_vld = vld5_reg;
    assign col_o   = col5_reg;
    assign body_o  = body_reg;

endmodule

// ----- hw/rtl/sarf_axis_pick.sv -----
// Largest-magnitude body axis selection and signed column output.
`timescale 1ns / 1ps

module sarf_axis_pick import sarf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int COL_W  = FRAC_BITS + 2,
    localparam int BODY_W = COL_W + AXIS_W + 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic signed [COL_W-1:0]  col_i [9],
    input  logic signed [BODY_W-1:0] body_i [3],
    output logic                     out_vld,
    output logic [OUT_W-1:0]         snapped_o [3],
    output logic [IDX_W-1:0]         idx_o,
    output logic                     neg_o
);

    localparam int EXT_W = (COL_W + 1 > OUT_W) ? COL_W + 1 : OUT_W;

    logic                     vld_reg;
    logic [OUT_W-1:0]         snap_reg  [3];
    logic [OUT_W-1:0]         snap_next [3];
    logic [IDX_W-1:0]         idx_reg, idx_next, idx_xy;
    logic                     neg_reg, neg_next;
    logic [BODY_W-1:0]        mag [3];
    logic [BODY_W-1:0]        mag_xy;
    logic signed [BODY_W-1:0] sel_body;
    logic signed [COL_W-1:0]  sel_col [3];
    logic signed [EXT_W-1:0]  ext_col;

    // Magnitudes of the body components
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag[k] = body_i[k][BODY_W-1] ? BODY_W'(-body_i[k]) : BODY_W'(body_i[k]);
        end
    end

    // Compare x with y, then the winner with z; ties keep the earlier axis
    always_comb begin
        idx_xy   = (mag[0] < mag[1]) ? IDX_Y : IDX_X;
        mag_xy   = (mag[0] < mag[1]) ? mag[1] : mag[0];
        idx_next = (mag_xy < mag[2]) ? IDX_Z : idx_xy;
    end

    // Select the chosen column and its body component
    always_comb begin
        case (idx_next)
            IDX_Y: begin
                sel_body = body_i[1];
                sel_col  = '{col_i[3], col_i[4], col_i[5]};
            end
            IDX_Z: begin
                sel_body = body_i[2];
                sel_col  = '{col_i[6], col_i[7], col_i[8]};
            end
            default: begin
                sel_body = body_i[0];
                sel_col  = '{col_i[0], col_i[1], col_i[2]};
            end
        endcase
        neg_next = sel_body[BODY_W-1];
    end

    // Negate the column when the component is negative
    always_comb begin
        ext_col = '0;
        for (int i = 0; i < 3; i++) begin
            ext_col      = EXT_W'(sel_col[i]);
            ext_col      = neg_next ? -ext_col : ext_col;
            snap_next[i] = ext_col[OUT_W-1:0];
        end
    end

    // Advance valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        if (en) begin
            snap_reg <= snap_next;
            idx_reg  <= idx_next;
            neg_reg  <= neg_next;
        end
    end

    assign out_vld   = vld_reg;
    assign snapped_o = snap_reg;
    assign idx_o     = idx_reg;
    assign neg_o     = neg_reg;

    // A valid result never carries the unused axis code
    a_idx_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg |-> idx_reg != IDX_RSVD)
        else $error("axis pick produced the unused axis code");

    // A stalled stage keeps its valid bit
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("axis pick valid changed during stall");

endmodule

// ----- hw/rtl/sarf_out_skid.sv -----
// Output register with a skid entry so upstream ready comes from a flop.
`timescale 1ns / 1ps

module sarf_out_skid #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic              out_vld_reg, skid_vld_reg;
    logic [DATA_W-1:0] out_data_reg, skid_data_reg;
    logic              accept_in, take_out;

    assign in_ready  = !skid_vld_reg;
    assign accept_in = in_valid && in_ready;
    assign take_out  = out_vld_reg && out_ready;

    // Control: fill the output register first, spill into the skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (accept_in) begin
            if (!out_vld_reg || out_ready) begin
                out_vld_reg <= 1'b1;
            end else begin
                skid_vld_reg <= 1'b1;
            end
        end else if (take_out) begin
            if (skid_vld_reg) begin
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload moves with the control above
    always_ff @(posedge aclk) begin
        if (accept_in) begin
            if (!out_vld_reg || out_ready) begin
                out_data_reg <= in_data;
            end else begin
                skid_data_reg <= in_data;
            end
        end else if (take_out && skid_vld_reg) begin
            out_data_reg <= skid_data_reg;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    // Skid entry only holds data behind a full output register
    a_skid_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry valid with empty output register");

    // An accepted transaction behind a stalled output lands in the skid entry
    a_spill: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_in && out_vld_reg && !out_ready |=> skid_vld_reg && out_vld_reg)
        else $error("transaction lost on output stall");

    // Draining with a full skid keeps the output valid and empties the skid
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        take_out && skid_vld_reg && !accept_in |=> out_vld_reg && !skid_vld_reg)
        else $error("skid entry not moved to output");

endmodule

// ----- hw/rtl/snap_axis_to_rotated_frame.sv -----
// Top level: snap a direction to the nearest signed axis of a rotated frame.
//
//  channel  dir  tdata (low bit up)                               tuser
//  s_axis   in   axis_x, axis_y, axis_z, quat_w, quat_x, quat_y,  -
//                quat_z (16 b each, 112 b)
//  m_axis   out  snapped_x, snapped_y, snapped_z                  chosen_index[1:0],
//                (16 b each, 48 b)                                chosen_negative[2]
//
//  One transaction per cycle while the output skid is empty; seven register stages.
//  Stages: quaternion products, matrix sums, round/clamp, dot products, dot sums,
//  axis pick, output register. The 16x16-bit multipliers set the stage depth.
//  Reset clears all valid bits and the output skid; payload registers are not reset.
//  An output stall fills the skid entry, then s_axis_tready drops and the whole
//  pipeline holds; s_axis_tready comes straight from a flop.
`timescale 1ns / 1ps

module snap_axis_to_rotated_frame import sarf_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // axis_x, axis_y, axis_z, quat_w, quat_x, quat_y, quat_z
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // snapped_x, snapped_y, snapped_z
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // chosen_index, chosen_negative
    output logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam int COL_W  = FRAC_BITS + 2;
    localparam int BODY_W = COL_W + AXIS_W + 2;
    localparam int SKID_W = SNAP_W + OUT_USER_W;

    logic                     pipe_en;
    logic signed [AXIS_W-1:0] axis_in [3];
    logic signed [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;
    logic                     mat_vld, dot_vld, pick_vld;
    logic signed [AXIS_W-1:0] mat_axis [3];
    logic signed [COL_W-1:0]  mat_col  [9];
    logic signed [COL_W-1:0]  dot_col  [9];
    logic signed [BODY_W-1:0] dot_body [3];
    logic [OUT_W-1:0]         snapped  [3];
    logic [IDX_W-1:0]         chosen_index;
    logic                     chosen_negative;
    logic [SKID_W-1:0]        skid_in, skid_out;

    // Unpack the input transaction
    assign axis_in[0] = s_axis_tdata[0*AXIS_W +: AXIS_W];
    assign axis_in[1] = s_axis_tdata[1*AXIS_W +: AXIS_W];
    assign axis_in[2] = s_axis_tdata[2*AXIS_W +: AXIS_W];
    assign quat_w     = s_axis_tdata[3*AXIS_W +: QUAT_W];
    assign quat_x     = s_axis_tdata[3*AXIS_W + 1*QUAT_W +: QUAT_W];
    assign quat_y     = s_axis_tdata[3*AXIS_W + 2*QUAT_W +: QUAT_W];
    assign quat_z     = s_axis_tdata[3*AXIS_W + 3*QUAT_W +: QUAT_W];

    // Hold the whole pipeline while the output skid is occupied
    assign s_axis_tready = pipe_en;

    sarf_quat_mat #(.FRAC_BITS(FRAC_BITS)) u_quat_mat (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .in_vld  (s_axis_tvalid),
        .axis_i  (axis_in),
        .quat_w  (quat_w),
        .quat_x  (quat_x),
        .quat_y  (quat_y),
        .quat_z  (quat_z),
        .out_vld (mat_vld),
        .axis_o  (mat_axis),
        .col_o   (mat_col)
    );

    sarf_body_dot #(.FRAC_BITS(FRAC_BITS)) u_body_dot (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (pipe_en),
        .in_vld  (mat_vld),
        .axis_i  (mat_axis),
        .col_i   (mat_col),
        .out_vld (dot_vld),
        .col_o   (dot_col),
        .body_o  (dot_body)
    );

    sarf_axis_pick #(.FRAC_BITS(FRAC_BITS)) u_axis_pick (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_vld    (dot_vld),
        .col_i     (dot_col),
        .body_i    (dot_body),
        .out_vld   (pick_vld),
        .snapped_o (snapped),
        .idx_o     (chosen_index),
        .neg_o     (chosen_negative)
    );

    // Pack result and flags for the output register
    assign skid_in = {chosen_negative, chosen_index, snapped[2], snapped[1], snapped[0]};

    sarf_out_skid #(.DATA_W(SKID_W)) u_out_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (pick_vld),
        .in_ready  (pipe_en),
        .in_data   (skid_in),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (skid_out)
    );

    assign m_axis_tdata = OUT_DATA_W'(skid_out[SNAP_W-1:0]);
    assign m_axis_tuser = skid_out[SKID_W-1:SNAP_W];

endmodule

// ----- test/tb_top.sv -----
// Self-checking stream testbench for the rotated-frame axis snapper.
`timescale 1ns / 1ps

module tb_top;
    import sarf_pkg::*;

    localparam int N_RANDOM  = 1500;
    localparam int PAUSE_AT  = 220;   // hold the sender here until the pipe drains
    localparam int QUIET_LO  = 700;   // no idling on either side in this item window
    localparam int QUIET_HI  = 1000;
    localparam int DRAIN_CYC = 16;    // pipeline depth is 7, keep some margin

    // One input transaction; first member ends up in the top bits
    typedef struct packed {
        logic signed [QUAT_W-1:0] qz;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qw;
        logic signed [AXIS_W-1:0] az;
        logic signed [AXIS_W-1:0] ay;
        logic signed [AXIS_W-1:0] ax;
    } pose_item_t;

    typedef struct {
        logic [OUT_W-1:0] sx;
        logic [OUT_W-1:0] sy;
        logic [OUT_W-1:0] sz;
        logic [IDX_W-1:0] idx;
        logic             neg;
    } snap_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;

    pose_item_t   pose_queue[$];
    snap_result_t expected_snaps[$];
    int           items_driven = 0;
    int           mismatch_count = 0;
    logic         in_taken = 1'b0;

    snap_axis_to_rotated_frame i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Round a Q2.2F product sum to Q1.F (add half, floor) and clamp to +/-1
    function automatic longint round_clamp_q(longint wide);
        longint one;
        longint r;
        one = longint'(1) << FRAC_BITS_DEF;
        r = (wide + (longint'(1) << (FRAC_BITS_DEF - 1))) >>> FRAC_BITS_DEF;
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Rotation columns, body-frame components, and the signed dominant column
    function automatic snap_result_t predict_snap(pose_item_t p);
        longint w, x, y, z, one2, c;
        longint v[3];
        longint col[3][3];
        longint body[3];
        logic [IDX_W-1:0] idx;
        snap_result_t r;
        w = longint'($signed(p.qw));
        x = longint'($signed(p.qx));
        y = longint'($signed(p.qy));
        z = longint'($signed(p.qz));
        v[0] = longint'($signed(p.ax));
        v[1] = longint'($signed(p.ay));
        v[2] = longint'($signed(p.az));
        one2 = longint'(1) << (2 * FRAC_BITS_DEF);
        col[0][0] = round_clamp_q(one2 - 2 * (y * y + z * z));
        col[0][1] = round_clamp_q(2 * (x * y + w * z));
        col[0][2] = round_clamp_q(2 * (x * z - w * y));
        col[1][0] = round_clamp_q(2 * (x * y - w * z));
        col[1][1] = round_clamp_q(one2 - 2 * (x * x + z * z));
        col[1][2] = round_clamp_q(2 * (y * z + w * x));
        col[2][0] = round_clamp_q(2 * (x * z + w * y));
        col[2][1] = round_clamp_q(2 * (y * z - w * x));
        col[2][2] = round_clamp_q(one2 - 2 * (x * x + y * y));
        for (int k = 0; k < 3; k++) begin
            body[k] = 0;
            for (int i = 0; i < 3; i++) begin
                body[k] += col[k][i] * v[i];
            end
        end
        // Ties keep the earlier axis
        idx = (magnitude(body[0]) < magnitude(body[1])) ? IDX_Y : IDX_X;
        if (magnitude(body[idx]) < magnitude(body[2])) begin
            idx = IDX_Z;
        end
        r.neg = (body[idx] < 0);
        r.idx = idx;
        c = r.neg ? -col[idx][0] : col[idx][0];
        r.sx = c[OUT_W-1:0];
        c = r.neg ? -col[idx][1] : col[idx][1];
        r.sy = c[OUT_W-1:0];
        c = r.neg ? -col[idx][2] : col[idx][2];
        r.sz = c[OUT_W-1:0];
        return r;
    endfunction

    function automatic pose_item_t mk_pose(int ax, int ay, int az, int qw, int qx, int qy,
                                           int qz);
        pose_item_t p;
        p.ax = ax[15:0];
        p.ay = ay[15:0];
        p.az = az[15:0];
        p.qw = qw[15:0];
        p.qx = qx[15:0];
        p.qy = qy[15:0];
        p.qz = qz[15:0];
        return p;
    endfunction

    // Random direction at a random scale, sometimes tiny to provoke ties
    function automatic logic [15:0] rand_axis();
        logic signed [15:0] a;
        a = 16'($urandom);
        case ($urandom_range(0, 3))
            0: return 16'($signed($urandom_range(0, 6)) - 3);
            1: return a >>> $urandom_range(0, 15);
            default: return a;
        endcase
    endfunction

    // Random near-unit quaternion, rounded to Q1.14
    function automatic pose_item_t unit_quat(pose_item_t p);
        real a, b, c, d, n;
        a = real'(int'($urandom_range(0, 65535)) - 32768);
        b = real'(int'($urandom_range(0, 65535)) - 32768);
        c = real'(int'($urandom_range(0, 65535)) - 32768);
        d = real'(int'($urandom_range(0, 65535)) - 32768);
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n == 0.0) begin
            a = 1.0;
            n = 1.0;
        end
        p.qw = 16'($rtoi(a / n * 16384.0 + ((a >= 0.0) ? 0.5 : -0.5)));
        p.qx = 16'($rtoi(b / n * 16384.0 + ((b >= 0.0) ? 0.5 : -0.5)));
        p.qy = 16'($rtoi(c / n * 16384.0 + ((c >= 0.0) ? 0.5 : -0.5)));
        p.qz = 16'($rtoi(d / n * 16384.0 + ((d >= 0.0) ? 0.5 : -0.5)));
        return p;
    endfunction

    // Quaternions whose matrix is a signed permutation, so ties survive the rotation
    function automatic pose_item_t aligned_quat(pose_item_t p);
        int q[4];
        case ($urandom_range(0, 8))
            0: q = '{16384, 0, 0, 0};
            1: q = '{11585, 11585, 0, 0};
            2: q = '{11585, 0, 11585, 0};
            3: q = '{11585, 0, 0, 11585};
            4: q = '{0, 16384, 0, 0};
            5: q = '{0, 0, 16384, 0};
            6: q = '{0, 0, 0, 16384};
            7: q = '{8192, 8192, 8192, 8192};
            default: q = '{8192, -8192, 8192, -8192};
        endcase
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 1) == 1) q[i] = -q[i];
        end
        p.qw = q[0][15:0];
        p.qx = q[1][15:0];
        p.qy = q[2][15:0];
        p.qz = q[3][15:0];
        return p;
    endfunction

    function automatic pose_item_t random_pose();
        pose_item_t p;
        int pick;
        p.ax = rand_axis();
        p.ay = rand_axis();
        p.az = rand_axis();
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            p = unit_quat(p);
        end else if (pick < 80) begin
            p = aligned_quat(p);
            p.ax = 16'($signed($urandom_range(0, 8)) - 4);
            p.ay = 16'($signed($urandom_range(0, 8)) - 4);
            p.az = 16'($signed($urandom_range(0, 8)) - 4);
        end else if (pick < 92) begin
            // off-norm but within nominal range
            p.qw = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.qx = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.qy = 16'($signed($urandom_range(0, 32768)) - 16384);
            p.qz = 16'($signed($urandom_range(0, 32768)) - 16384);
        end else begin
            p = pose_item_t'(IN_DATA_W'({$urandom, $urandom, $urandom, $urandom}));
        end
        return p;
    endfunction

    task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            mismatch_count++;
        end
    endtask

    // Driver: present the next pose when the current one is taken or absent
    always @(negedge aclk) begin
        logic quiet;
        logic idle;
        quiet = (items_driven >= QUIET_LO) && (items_driven < QUIET_HI);
        idle = (!quiet && $urandom_range(0, 99) < 15) ||
               (items_driven == PAUSE_AT && expected_snaps.size() != 0);
        if (aresetn) begin
            if (!s_axis_tvalid || in_taken) begin
                if (pose_queue.size() == 0 || idle) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    s_axis_tdata <= pose_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    items_driven <= items_driven + 1;
                end
            end
            m_axis_tready <= quiet || ($urandom_range(0, 99) >= 15);
        end
    end

    // Monitor: predict on input accept, compare on output accept
    always @(posedge aclk) begin
        snap_result_t want;
        if (aresetn) begin
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                expected_snaps.push_back(predict_snap(pose_item_t'(s_axis_tdata)));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_snaps.size() == 0) begin
                    $display("%0t: unexpected result expected none actual %0h/%0h", $time,
                             m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    want = expected_snaps.pop_front();
                    check_field("snapped_x", want.sx, m_axis_tdata[15:0]);
                    check_field("snapped_y", want.sy, m_axis_tdata[31:16]);
                    check_field("snapped_z", want.sz, m_axis_tdata[47:32]);
                    check_field("chosen_index", 16'(want.idx), 16'(m_axis_tuser[1:0]));
                    check_field("chosen_negative", 16'(want.neg), 16'(m_axis_tuser[2]));
                end
            end
        end
    end

    initial begin
        // Directed: zero vector, extremes, ties, signs, saturating quaternions
        pose_queue.push_back(mk_pose(0, 0, 0, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(0, 0, 0, 8192, 8192, 8192, 8192));
        pose_queue.push_back(mk_pose(32767, 0, 0, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(-32768, 0, 0, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(0, -32768, 0, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(0, 0, 32767, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(5, 5, 0, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(5, -5, 0, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(0, -7, 7, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(3, 0, -3, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(-32768, -32768, -32768, 16384, 0, 0, 0));
        pose_queue.push_back(mk_pose(1, 2, 3, -16384, -16384, -16384, -16384));
        pose_queue.push_back(mk_pose(-9, 4, 1, 16384, 16384, 16384, 16384));
        pose_queue.push_back(mk_pose(32767, 32767, 32767, -32768, -32768, -32768, -32768));
        pose_queue.push_back(mk_pose(-32768, 100, -1, 32767, 32767, 32767, 32767));
        pose_queue.push_back(mk_pose(1, 0, 0, 11585, 0, 0, 11585));
        pose_queue.push_back(mk_pose(0, 1, 0, 0, 16384, 0, 0));
        pose_queue.push_back(mk_pose(100, -200, 300, 0, 0, 0, 0));
        pose_queue.push_back(mk_pose('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555));
        pose_queue.push_back(mk_pose('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA));
        pose_queue.push_back(mk_pose(-1, -1, -1, 8192, -8192, 8192, -8192));
        for (int n = 0; n < N_RANDOM; n++) begin
            pose_queue.push_back(random_pose());
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Drain: all poses taken, all results returned, then watch for extras
        while (pose_queue.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (expected_snaps.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("snap_axis_to_rotated_frame: match");
        end else begin
            $display("snap_axis_to_rotated_frame: mismatch");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("snap_axis_to_rotated_frame: mismatch");
        $finish;
    end

endmodule
